>>> hdl/tpb_pkg.sv
// Shared constants, types and register codes for the track polyline builder.
package tpb_pkg;

    localparam int TRACK_DEPTH = 1024;
    localparam int POLY_MAX    = 64;
    localparam int COORD_LIMIT = 32767;
    localparam int VIEW_MARGIN = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam int IDX_W  = $clog2(TRACK_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DVD_W  = CNT_W + 7;
    localparam int WALK_W = DVD_W + 1;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] CFG_CTR_LAT     = 3'd0;
    localparam logic [2:0] CFG_CTR_LON     = 3'd1;
    localparam logic [2:0] CFG_SCALE_LON   = 3'd2;
    localparam logic [2:0] CFG_SCALE_LAT   = 3'd3;
    localparam logic [2:0] CFG_HALF_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_HALF_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_PROJ_VALID  = 3'd6;
    localparam logic [2:0] CFG_PT_LIMIT    = 3'd7;

    typedef struct packed {
        logic [30:0] ctr_lat;
        logic [31:0] ctr_lon;
        logic [31:0] scale_lon;
        logic [31:0] scale_lat;
        logic [11:0] half_w;
        logic [11:0] half_h;
        logic        proj_valid;
        logic [6:0]  pt_limit;
    } cfg_t;

    // projected point as it travels from front to back
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        ok;
        logic        last;
    } pt_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last_point;
        logic        empty_res;
    } res_t;

endpackage

>>> hdl/tpb_ifaces.sv
// Channel interfaces: track input, polyline output, register writes.
interface tpb_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] lat;
    logic [31:0] lon;
    logic        entry_ok;
    logic        is_last;
    modport source(output valid, lat, lon, entry_ok, is_last, input ready);
    modport sink(input valid, lat, lon, entry_ok, is_last, output ready);
endinterface

interface tpb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] x;
    logic [15:0] y;
    logic        last_point;
    logic        empty_res;
    modport source(output valid, x, y, last_point, empty_res, input ready);
    modport sink(input valid, x, y, last_point, empty_res, output ready);
endinterface

interface tpb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/tpb_front.sv
// Front end: accepts track points and projects them to screen pixels.
module tpb_front (
    input  logic          clk,
    input  logic          rst_n,
    tpb_in_if.sink        in_ch,
    input  tpb_pkg::cfg_t cfg,
    output tpb_pkg::pt_t  push_data,
    output logic          push_valid,
    input  logic          push_ready
);
    import tpb_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_SUM  = 3'd2;
    localparam logic [2:0] F_RND  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]  state_reg;
    logic [30:0] lat_reg;
    logic [31:0] lon_reg;
    logic        ok_reg;
    logic        last_reg;
    logic [63:0] lo_x_reg;
    logic [63:0] lo_y_reg;
    logic        mh_x_reg;
    logic        mh_y_reg;
    logic        neg_x_reg;
    logic        neg_y_reg;
    logic [66:0] n_x_reg;
    logic [66:0] n_y_reg;
    logic [15:0] px_reg;
    logic [15:0] py_reg;

    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] mx;
    logic [32:0] my;
    logic [64:0] prod_x;
    logic [64:0] prod_y;
    logic [66:0] base_x;
    logic [66:0] base_y;
    logic        in_fire;

    // round half away from zero, then saturate; n is the value times 2^32
    function automatic logic [15:0] round_sat(input logic [66:0] n);
        logic [66:0] a;
        logic [66:0] t;
        logic [34:0] r;
        logic [15:0] m;
        a = n[66] ? (67'd0 - n) : n;
        t = a + (67'd1 << 31);
        r = t[66:32];
        m = (r > 35'(COORD_LIMIT)) ? 16'(COORD_LIMIT) : r[15:0];
        return n[66] ? (16'd0 - m) : m;
    endfunction

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == F_IDLE);

    assign dx = {lon_reg[31], lon_reg} - {cfg.ctr_lon[31], cfg.ctr_lon};
    assign dy = {{2{lat_reg[30]}}, lat_reg} - {{2{cfg.ctr_lat[30]}}, cfg.ctr_lat};
    assign mx = dx[32] ? (33'd0 - dx) : dx;
    assign my = dy[32] ? (33'd0 - dy) : dy;

    assign prod_x = {1'b0, lo_x_reg} + (mh_x_reg ? {1'b0, cfg.scale_lon, 32'd0} : 65'd0);
    assign prod_y = {1'b0, lo_y_reg} + (mh_y_reg ? {1'b0, cfg.scale_lat, 32'd0} : 65'd0);
    assign base_x = {23'd0, cfg.half_w, 32'd0};
    assign base_y = {23'd0, cfg.half_h, 32'd0};

    assign push_valid  = (state_reg == F_PUSH);
    assign push_data.x    = px_reg;
    assign push_data.y    = py_reg;
    assign push_data.ok   = ok_reg;
    assign push_data.last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_fire)
                        state_reg <= F_MUL;
                end
                F_MUL:  state_reg <= F_SUM;
                F_SUM:  state_reg <= F_RND;
                F_RND:  state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (push_ready)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lat_reg  <= in_ch.lat;
            lon_reg  <= in_ch.lon;
            ok_reg   <= in_ch.entry_ok;
            last_reg <= in_ch.is_last;
        end
        if (state_reg == F_MUL)
        begin
            lo_x_reg  <= mx[31:0] * cfg.scale_lon;
            lo_y_reg  <= my[31:0] * cfg.scale_lat;
            mh_x_reg  <= mx[32];
            mh_y_reg  <= my[32];
            neg_x_reg <= dx[32];
            neg_y_reg <= dy[32];
        end
        if (state_reg == F_SUM)
        begin
            // x grows with longitude, y shrinks with latitude
            n_x_reg <= neg_x_reg ? (base_x - {2'b00, prod_x}) : (base_x + {2'b00, prod_x});
            n_y_reg <= neg_y_reg ? (base_y + {2'b00, prod_y}) : (base_y - {2'b00, prod_y});
        end
        if (state_reg == F_RND)
        begin
            px_reg <= cfg.proj_valid ? round_sat(n_x_reg) : {4'd0, cfg.half_w};
            py_reg <= cfg.proj_valid ? round_sat(n_y_reg) : {4'd0, cfg.half_h};
        end
    end

endmodule

>>> hdl/tpb_fifo.sv
// Short queue between the projection front end and the track back end.
module tpb_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  tpb_pkg::pt_t push_data,
    input  logic         push_valid,
    output logic         push_ready,
    output tpb_pkg::pt_t pop_data,
    output logic         pop_valid,
    input  logic         pop_ready
);
    import tpb_pkg::*;

    pt_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                fill_reg <= fill_reg + 1'b1;
            else if (pop_fire && !push_fire)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/tpb_back.sv
// Back end: point store, visibility scan, stride divider and polyline walk.
module tpb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tpb_pkg::pt_t  pop_data,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  tpb_pkg::cfg_t cfg,
    tpb_out_if.source     out_ch
);
    import tpb_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SRD   = 3'd1;
    localparam logic [2:0] B_SCHK  = 3'd2;
    localparam logic [2:0] B_SPAN  = 3'd3;
    localparam logic [2:0] B_DIV   = 3'd4;
    localparam logic [2:0] B_WRD   = 3'd5;
    localparam logic [2:0] B_WCHK  = 3'd6;
    localparam logic [2:0] B_FLUSH = 3'd7;

    logic [2:0]        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  last_reg;
    logic              any_reg;
    logic [WALK_W-1:0] pos_reg;
    logic [IDX_W-1:0]  hi_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [7:0]        rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [6:0]        written_reg;
    logic              have_pend_reg;
    logic [15:0]       pend_x_reg;
    logic [15:0]       pend_y_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;

    logic [32:0]       mem [TRACK_DEPTH];
    logic [32:0]       rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;

    logic [15:0]       e_x;
    logic [15:0]       e_y;
    logic              e_ok;
    logic              vis;
    logic [16:0]       xs;
    logic [16:0]       ys;
    logic [16:0]       x_lim;
    logic [16:0]       y_lim;
    logic [6:0]        mpc;
    logic              out_free;
    logic              out_load;
    logic              pop_fire;
    logic              room;
    logic [IDX_W-1:0]  lo_idx;
    logic [IDX_W-1:0]  hi_idx;
    logic [CNT_W-1:0]  span;
    logic [DVD_W-1:0]  dividend;
    logic [7:0]        r2;
    logic              ge;
    logic              dup;
    logic              take;
    logic              wchk_go;
    logic              hit;

    assign e_x  = rd_data_reg[15:0];
    assign e_y  = rd_data_reg[31:16];
    assign e_ok = rd_data_reg[32];

    // viewport test with margin, in 17-bit signed
    assign xs    = {e_x[15], e_x};
    assign ys    = {e_y[15], e_y};
    assign x_lim = {4'd0, cfg.half_w, 1'b0} + 17'(VIEW_MARGIN);
    assign y_lim = {4'd0, cfg.half_h, 1'b0} + 17'(VIEW_MARGIN);
    assign vis   = ($signed(xs) >= -$signed(17'(VIEW_MARGIN)))
                && ($signed(ys) >= -$signed(17'(VIEW_MARGIN)))
                && ($signed(xs) <= $signed(x_lim))
                && ($signed(ys) <= $signed(y_lim));
    assign hit   = e_ok && vis;

    assign mpc = (cfg.pt_limit == 7'd0) ? 7'd1 :
                 (cfg.pt_limit > 7'(POLY_MAX)) ? 7'(POLY_MAX) : cfg.pt_limit;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign pop_ready = (state_reg == B_IDLE);
    assign pop_fire  = pop_valid && pop_ready;
    assign room      = (cnt_reg < CNT_W'(TRACK_DEPTH));

    // widen the visible range by one point on each side
    assign lo_idx   = (first_reg != '0) ? (first_reg - 1'b1) : first_reg;
    assign hi_idx   = (({1'b0, last_reg} + 1'b1) < total_reg) ? (last_reg + 1'b1) : last_reg;
    assign span     = {1'b0, hi_idx} - {1'b0, lo_idx} + 1'b1;
    assign dividend = DVD_W'(span) + DVD_W'(mpc) - 1'b1;

    // one restoring divide step per cycle: stride = ceil(span / mpc)
    assign r2 = {rem_reg[6:0], dvd_reg[DVD_W-1]};
    assign ge = (r2 >= {1'b0, mpc});

    assign dup     = have_pend_reg && (e_x == pend_x_reg) && (e_y == pend_y_reg);
    assign take    = e_ok && !dup;
    assign wchk_go = !take || !have_pend_reg || out_free;

    // a new word enters the output register
    assign out_load = ((state_reg == B_WCHK) && wchk_go && take && have_pend_reg)
                   || ((state_reg == B_FLUSH) && out_free);

    assign rd_addr = (state_reg == B_SRD) ? idx_reg[IDX_W-1:0] : pos_reg[IDX_W-1:0];

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.x          = out_data_reg.x;
    assign out_ch.y          = out_data_reg.y;
    assign out_ch.last_point = out_data_reg.last_point;
    assign out_ch.empty_res  = out_data_reg.empty_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            any_reg       <= 1'b0;
            pos_reg       <= '0;
            hi_reg        <= '0;
            dvd_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            written_reg   <= '0;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_fire)
                    begin
                        if (pop_data.last)
                        begin
                            total_reg <= room ? (cnt_reg + 1'b1) : cnt_reg;
                            cnt_reg   <= '0;
                            any_reg   <= 1'b0;
                            first_reg <= '0;
                            last_reg  <= '0;
                            idx_reg   <= '0;
                            state_reg <= B_SRD;
                        end
                        else if (room)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                B_SRD: state_reg <= B_SCHK;
                B_SCHK:
                begin
                    if (hit)
                    begin
                        if (!any_reg)
                            first_reg <= idx_reg[IDX_W-1:0];
                        any_reg  <= 1'b1;
                        last_reg <= idx_reg[IDX_W-1:0];
                    end
                    idx_reg       <= idx_reg + 1'b1;
                    have_pend_reg <= 1'b0;
                    if ((idx_reg + 1'b1) == total_reg)
                        state_reg <= (any_reg || hit) ? B_SPAN : B_FLUSH;
                    else
                        state_reg <= B_SRD;
                end
                B_SPAN:
                begin
                    pos_reg     <= WALK_W'(lo_idx);
                    hi_reg      <= hi_idx;
                    dvd_reg     <= dividend;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    step_reg    <= '0;
                    written_reg <= '0;
                    state_reg   <= B_DIV;
                end
                B_DIV:
                begin
                    rem_reg  <= ge ? (r2 - {1'b0, mpc}) : r2;
                    quo_reg  <= {quo_reg[DVD_W-2:0], ge};
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DVD_W - 1))
                        state_reg <= B_WRD;
                end
                B_WRD:
                begin
                    if ((pos_reg > WALK_W'(hi_reg)) || (written_reg >= mpc))
                        state_reg <= B_FLUSH;
                    else
                        state_reg <= B_WCHK;
                end
                B_WCHK:
                begin
                    if (wchk_go)
                    begin
                        if (take)
                        begin
                            have_pend_reg <= 1'b1;
                            written_reg   <= written_reg + 1'b1;
                        end
                        pos_reg   <= pos_reg + WALK_W'(quo_reg);
                        state_reg <= B_WRD;
                    end
                end
                B_FLUSH:
                begin
                    if (out_free)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire && room)
            mem[cnt_reg[IDX_W-1:0]] <= {pop_data.ok, pop_data.y, pop_data.x};
        if ((state_reg == B_SRD) || (state_reg == B_WRD))
            rd_data_reg <= mem[rd_addr];
        if ((state_reg == B_WCHK) && wchk_go && take)
        begin
            pend_x_reg <= e_x;
            pend_y_reg <= e_y;
            if (have_pend_reg)
                out_data_reg <= '{x: pend_x_reg, y: pend_y_reg,
                                  last_point: 1'b0, empty_res: 1'b0};
        end
        if ((state_reg == B_FLUSH) && out_free)
        begin
            if (have_pend_reg)
                out_data_reg <= '{x: pend_x_reg, y: pend_y_reg,
                                  last_point: 1'b1, empty_res: 1'b0};
            else
                out_data_reg <= '{x: 16'd0, y: 16'd0, last_point: 1'b1, empty_res: 1'b1};
        end
    end

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.empty_res |-> out_data_reg.last_point)
        else $error("empty result without last_point");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WCHK |-> written_reg < mpc)
        else $error("walk exceeded max points");

    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && pop_data.last |=> state_reg == B_SRD)
        else $error("end of track did not start scan");

    a_stride_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WCHK |-> quo_reg != '0)
        else $error("zero walk stride");

endmodule

>>> hdl/track_polyline_builder_top.sv
// Top level: register file, projection front end, queue and track back end.
//
// Channels: in_ch takes one track point per word (lat, lon, entry_ok, is_last);
// out_ch gives polyline points (x, y, last_point, empty_res); cfg_ch writes one
// register per word and is always ready.
// Each point passes through the projection front end (two 32x32 products,
// a wide add, then round and clamp), and the front takes no new point until
// the previous one is in the queue; a 4-word queue lets the front keep
// projecting while the back is busy. Non-final points give no result. On
// the point with is_last the back end reads and then checks each stored
// point, divides the span for the walk stride, and then walks, reading and
// checking each visited point; the 1024-entry point store has one port.
// Results pass through an output register; a stalled receiver holds the walk
// but the front and queue keep taking points until the queue fills.
// Reset clears the registers to their defaults (point limit 64) and empties
// the track; the store needs no clearing.
module track_polyline_builder_top (
    input  logic      clk,
    input  logic      rst_n,
    tpb_in_if.sink    in_ch,
    tpb_out_if.source out_ch,
    tpb_cfg_if.sink   cfg_ch
);
    import tpb_pkg::*;

    cfg_t cfg_reg;
    pt_t  push_data;
    logic push_valid;
    logic push_ready;
    pt_t  pop_data;
    logic pop_valid;
    logic pop_ready;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ctr_lat: '0, ctr_lon: '0, scale_lon: '0, scale_lat: '0,
                         half_w: '0, half_h: '0, proj_valid: 1'b0,
                         pt_limit: 7'(POLY_MAX)};
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_CTR_LAT:     cfg_reg.ctr_lat    <= cfg_ch.data[30:0];
                CFG_CTR_LON:     cfg_reg.ctr_lon    <= cfg_ch.data;
                CFG_SCALE_LON:   cfg_reg.scale_lon  <= cfg_ch.data;
                CFG_SCALE_LAT:   cfg_reg.scale_lat  <= cfg_ch.data;
                CFG_HALF_WIDTH:  cfg_reg.half_w     <= cfg_ch.data[11:0];
                CFG_HALF_HEIGHT: cfg_reg.half_h     <= cfg_ch.data[11:0];
                CFG_PROJ_VALID:  cfg_reg.proj_valid <= cfg_ch.data[0];
                CFG_PT_LIMIT:    cfg_reg.pt_limit   <= cfg_ch.data[6:0];
                default: ;
            endcase
        end
    end

    tpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tpb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .cfg       (cfg_reg),
        .out_ch    (out_ch)
    );

endmodule
